/* src/cscan_pkg.sv */
// Shared types and constants for the C-SCAN disk scheduler.
// Holds the payload structs, configuration indexes, microcode types and the track clamp.
// No dependencies.
`default_nettype none

package cscan_pkg;

    localparam int TRACK_W = 16;
    localparam int SEEK_W  = 18;

    localparam logic [TRACK_W-1:0] MAX_TRACK_RST = 16'd199;

    // Configuration register indexes.
    localparam logic CFG_MAX_TRACK = 1'b0;
    localparam logic CFG_SWEEP_DIR = 1'b1;

    // Item kinds.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    // Sweep directions.
    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [TRACK_W-1:0] request_track;
        logic [TRACK_W-1:0] head_position;
    } t_in_item;

    typedef struct packed {
        logic [TRACK_W-1:0] service_track;
        logic               is_last;
        logic [SEEK_W-1:0]  total_seek;
        logic               requests_dropped;
    } t_out_item;

    // Microcode operation kinds.
    typedef enum logic [2:0] {
        UOP_EMIT,
        UOP_REPEAT,
        UOP_LOOP,
        UOP_SCAN,
        UOP_DONE
    } t_uop;

    // Source of the emitted track and of the store read address.
    typedef enum logic [2:0] {
        SRC_HEAD,
        SRC_STORE,
        SRC_STORE_M1,
        SRC_EDGE,
        SRC_ZERO
    } t_src;

    typedef enum logic [2:0] {
        C_NEVER,
        C_SCAN,
        C_IDX_LT_N,
        C_IDX_GT_0,
        C_SPLIT_Z,
        C_SPLIT_N,
        C_LAST_UP,
        C_LAST_DN
    } t_cond;

    typedef enum logic [2:0] {
        IDX_KEEP,
        IDX_INC,
        IDX_DEC,
        IDX_ZERO,
        IDX_COUNT
    } t_idx_op;

    typedef enum logic [2:0] {
        SEEK_NONE,
        SEEK_TO_EDGE,
        SEEK_HEAD,
        SEEK_WRAP_UP,
        SEEK_WRAP_DN
    } t_seek;

    typedef logic [3:0] t_upc;

    localparam t_upc UPC_HEAD  = 4'd0;
    localparam t_upc UPC_SCAN  = 4'd1;
    localparam t_upc UPC_UP1   = 4'd2;
    localparam t_upc UPC_EDGE  = 4'd3;
    localparam t_upc UPC_ZERO  = 4'd4;
    localparam t_upc UPC_UP2   = 4'd5;
    localparam t_upc UPC_DN1   = 4'd6;
    localparam t_upc UPC_ZEROE = 4'd7;
    localparam t_upc UPC_EDGE2 = 4'd8;
    localparam t_upc UPC_DN2   = 4'd9;
    localparam t_upc UPC_DONE  = 4'd10;

    typedef struct packed {
        t_uop    op;
        t_src    src;
        t_cond   cond;
        t_idx_op idx_op;
        t_seek   seek;
        t_upc    target;
    } t_uword;

    // Sequencer to datapath.
    typedef struct packed {
        logic    emit;
        logic    idx_upd;
        logic    split_ld;
        logic    done;
        logic    last;
        t_src    src;
        t_cond   cond;
        t_idx_op idx_op;
        t_seek   seek;
    } t_ctrl;

    // Datapath to sequencer.
    typedef struct packed {
        logic cond;
        logic slot_free;
    } t_status;

    function automatic logic [TRACK_W-1:0] clamp_track(
        input logic [TRACK_W-1:0] track,
        input logic [TRACK_W-1:0] edge_trk
    );
        return (track > edge_trk) ? edge_trk : track;
    endfunction

endpackage

`default_nettype wire

/* src/cscan_disk_scheduler_core.sv */
// C-SCAN disk scheduler. A load item (req_type 0) stores a request track, clamped to
// max_track, into a store of MAX_REQUESTS entries kept in ascending order; it gives no
// result, and a load into a full store is dropped and flagged. A run item (req_type 1)
// starts a microcoded sequencer that walks the sorted store one entry per cycle: it first
// locates the head in the list, then emits one result per cycle while the output is not
// stalled: the head, the requests of the first sweep, the edge, the opposite edge after
// the wrap and the remaining requests, n+2 to n+3 results in all for n stored requests.
// The input is stalled for the whole run. The last result carries the total seek and
// is_last; every result of a run carries the dropped flag. The store and the flag empty
// after each run.
// Depends on cscan_pkg, cscan_store, cscan_useq and cscan_dpath.
`default_nettype none

module cscan_disk_scheduler_core #(
    parameter int MAX_REQUESTS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire cscan_pkg::t_in_item           i_in_item,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output cscan_pkg::t_out_item               o_out_item,
    input  wire logic                          i_out_stall,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [cscan_pkg::TRACK_W-1:0] i_cfg_data
);
    import cscan_pkg::*;

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    logic [TRACK_W-1:0] r_max_track;
    logic               r_sweep_dir;
    logic               busy;
    logic               in_xfer;
    logic               load;
    logic               start;
    logic [AW-1:0]      rd_addr;
    logic [TRACK_W-1:0] rd_track;
    logic [CW-1:0]      count;
    logic               overflow;
    t_ctrl              ctrl;
    t_status            status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_track <= MAX_TRACK_RST;
            r_sweep_dir <= DIR_UP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_TRACK: r_max_track <= i_cfg_data;
                CFG_SWEEP_DIR: r_sweep_dir <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = busy;
    assign in_xfer    = i_in_valid && !busy;
    assign load       = in_xfer && (i_in_item.req_type == REQ_LOAD);
    assign start      = in_xfer && (i_in_item.req_type == REQ_RUN);

    cscan_store #(
        .MAX_REQUESTS(MAX_REQUESTS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_track     (i_in_item.request_track),
        .i_clear     (ctrl.done),
        .i_max_track (r_max_track),
        .i_rd_addr   (rd_addr),
        .o_rd_track  (rd_track),
        .o_count     (count),
        .o_overflow  (overflow)
    );

    cscan_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_dir    (r_sweep_dir),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    cscan_dpath #(
        .MAX_REQUESTS(MAX_REQUESTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_head      (i_in_item.head_position),
        .i_max_track (r_max_track),
        .i_dir       (r_sweep_dir),
        .i_count     (count),
        .i_overflow  (overflow),
        .i_rd_track  (rd_track),
        .i_ctrl      (ctrl),
        .i_out_stall (i_out_stall),
        .o_rd_addr   (rd_addr),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* src/cscan_store.sv */
// Sorted request store for the C-SCAN scheduler.
// Inserts each load in ascending order and serves one read per cycle.
// Depends on cscan_pkg.
`default_nettype none

module cscan_store #(
    parameter int MAX_REQUESTS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire logic [cscan_pkg::TRACK_W-1:0] i_track,
    input  wire logic                        i_clear,
    input  wire logic [cscan_pkg::TRACK_W-1:0] i_max_track,
    input  wire logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] i_rd_addr,
    output logic [cscan_pkg::TRACK_W-1:0]    o_rd_track,
    output logic [$clog2(MAX_REQUESTS+1)-1:0] o_count,
    output logic                             o_overflow
);
    import cscan_pkg::*;

    localparam int CW = $clog2(MAX_REQUESTS + 1);

    logic [TRACK_W-1:0] r_mem [MAX_REQUESTS];
    logic [TRACK_W-1:0] n_mem [MAX_REQUESTS];
    logic [CW-1:0]      r_count;
    logic               r_overflow;
    logic [MAX_REQUESTS-1:0] gt;
    logic [TRACK_W-1:0] ld_track;
    logic               full;
    logic               ins;

    assign ld_track = clamp_track(i_track, i_max_track);
    assign full     = (r_count == CW'(MAX_REQUESTS));
    assign ins      = i_load && !full;

    // Entries above the new track move up one place; the first of them takes the new track.
    always_comb begin
        gt = '0;
        for (int k = 0; k < MAX_REQUESTS; k++) begin
            gt[k] = (CW'(k) < r_count) && (r_mem[k] > ld_track);
        end
        for (int k = 0; k < MAX_REQUESTS; k++) begin
            n_mem[k] = r_mem[k];
        end
        if (ins && (gt[0] || r_count == CW'(0))) begin
            n_mem[0] = ld_track;
        end
        for (int k = 1; k < MAX_REQUESTS; k++) begin
            if (ins) begin
                if (gt[k-1]) begin
                    n_mem[k] = r_mem[k-1];
                end else if (gt[k] || r_count == CW'(k)) begin
                    n_mem[k] = ld_track;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_REQUESTS; k++) begin
            r_mem[k] <= n_mem[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_clear) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_load) begin
            if (full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Stored tracks are clamped again in case the edge was lowered after loading.
    assign o_rd_track = clamp_track(r_mem[i_rd_addr], i_max_track);
    assign o_count    = r_count;
    assign o_overflow = r_overflow;

endmodule

`default_nettype wire

/* src/cscan_useq.sv */
// Microcode sequencer for the C-SCAN scheduler.
// Holds the step counter and the control ROM and issues one control word per cycle.
// Depends on cscan_pkg.
`default_nettype none

module cscan_useq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_dir,
    input  wire cscan_pkg::t_status i_status,
    output cscan_pkg::t_ctrl        o_ctrl,
    output logic                    o_busy
);
    import cscan_pkg::*;

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w = '{op: UOP_DONE, src: SRC_ZERO, cond: C_NEVER, idx_op: IDX_KEEP,
              seek: SEEK_NONE, target: UPC_DONE};
        case (pc)
            UPC_HEAD:  w = '{op: UOP_EMIT, src: SRC_HEAD, cond: C_NEVER,
                             idx_op: IDX_ZERO, seek: SEEK_NONE, target: UPC_SCAN};
            UPC_SCAN:  w = '{op: UOP_SCAN, src: SRC_STORE, cond: C_SCAN,
                             idx_op: IDX_INC, seek: SEEK_NONE, target: UPC_DN1};
            UPC_UP1:   w = '{op: UOP_LOOP, src: SRC_STORE, cond: C_IDX_LT_N,
                             idx_op: IDX_INC, seek: SEEK_NONE, target: UPC_EDGE};
            UPC_EDGE:  w = '{op: UOP_EMIT, src: SRC_EDGE, cond: C_SPLIT_Z,
                             idx_op: IDX_ZERO, seek: SEEK_TO_EDGE, target: UPC_DONE};
            UPC_ZERO:  w = '{op: UOP_EMIT, src: SRC_ZERO, cond: C_NEVER,
                             idx_op: IDX_KEEP, seek: SEEK_NONE, target: UPC_UP2};
            UPC_UP2:   w = '{op: UOP_REPEAT, src: SRC_STORE, cond: C_LAST_UP,
                             idx_op: IDX_INC, seek: SEEK_WRAP_UP, target: UPC_DONE};
            UPC_DN1:   w = '{op: UOP_LOOP, src: SRC_STORE_M1, cond: C_IDX_GT_0,
                             idx_op: IDX_DEC, seek: SEEK_NONE, target: UPC_ZEROE};
            UPC_ZEROE: w = '{op: UOP_EMIT, src: SRC_ZERO, cond: C_SPLIT_N,
                             idx_op: IDX_KEEP, seek: SEEK_HEAD, target: UPC_DONE};
            UPC_EDGE2: w = '{op: UOP_EMIT, src: SRC_EDGE, cond: C_NEVER,
                             idx_op: IDX_COUNT, seek: SEEK_NONE, target: UPC_DN2};
            UPC_DN2:   w = '{op: UOP_REPEAT, src: SRC_STORE_M1, cond: C_LAST_DN,
                             idx_op: IDX_DEC, seek: SEEK_WRAP_DN, target: UPC_DONE};
            default:   w = '{op: UOP_DONE, src: SRC_ZERO, cond: C_NEVER,
                             idx_op: IDX_KEEP, seek: SEEK_NONE, target: UPC_DONE};
        endcase
        return w;
    endfunction

    logic   r_busy, n_busy;
    t_upc   r_pc, n_pc;
    t_uword uw;
    logic   is_emit_op;

    assign uw         = ucode(r_pc);
    assign is_emit_op = (uw.op == UOP_EMIT) || (uw.op == UOP_REPEAT);

    always_comb begin
        o_ctrl.src      = uw.src;
        o_ctrl.cond     = uw.cond;
        o_ctrl.idx_op   = uw.idx_op;
        o_ctrl.seek     = uw.seek;
        o_ctrl.last     = is_emit_op && i_status.cond;
        o_ctrl.emit     = r_busy && i_status.slot_free
                          && (is_emit_op || (uw.op == UOP_LOOP && i_status.cond));
        o_ctrl.idx_upd  = r_busy && ((i_status.slot_free
                          && (is_emit_op || (uw.op == UOP_LOOP && i_status.cond)))
                          || (uw.op == UOP_SCAN && i_status.cond));
        o_ctrl.split_ld = r_busy && (uw.op == UOP_SCAN) && !i_status.cond;
        o_ctrl.done     = r_busy && (uw.op == UOP_DONE);
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = UPC_HEAD;
            end
        end else begin
            case (uw.op)
                UOP_EMIT: begin
                    if (i_status.slot_free) begin
                        n_pc = i_status.cond ? uw.target : r_pc + 1'b1;
                    end
                end
                UOP_REPEAT: begin
                    if (i_status.slot_free && i_status.cond) begin
                        n_pc = uw.target;
                    end
                end
                UOP_LOOP: begin
                    if (!i_status.cond) begin
                        n_pc = uw.target;
                    end
                end
                UOP_SCAN: begin
                    // The downward program sits apart from the upward one.
                    if (!i_status.cond) begin
                        n_pc = (i_dir == DIR_DOWN) ? uw.target : r_pc + 1'b1;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UPC_HEAD;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

/* src/cscan_dpath.sv */
// Datapath of the C-SCAN scheduler: index, split point, head, seek adder and output register.
// Evaluates the condition that the current control word selects.
// Depends on cscan_pkg.
`default_nettype none

module cscan_dpath #(
    parameter int MAX_REQUESTS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [cscan_pkg::TRACK_W-1:0] i_head,
    input  wire logic [cscan_pkg::TRACK_W-1:0] i_max_track,
    input  wire logic                          i_dir,
    input  wire logic [$clog2(MAX_REQUESTS+1)-1:0] i_count,
    input  wire logic                          i_overflow,
    input  wire logic [cscan_pkg::TRACK_W-1:0] i_rd_track,
    input  wire cscan_pkg::t_ctrl              i_ctrl,
    input  wire logic                          i_out_stall,
    output logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] o_rd_addr,
    output cscan_pkg::t_status                 o_status,
    output logic                               o_out_valid,
    output cscan_pkg::t_out_item               o_out_item
);
    import cscan_pkg::*;

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_split;
    logic [TRACK_W-1:0] r_head;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [CW-1:0]      rd_idx;
    logic               cond;
    logic               slot_free;
    logic [TRACK_W-1:0] trk;
    logic [SEEK_W-1:0]  seek_val;
    logic [SEEK_W-1:0]  e18, h18, v18;

    assign rd_idx    = (i_ctrl.src == SRC_STORE_M1) ? r_idx - 1'b1 : r_idx;
    assign o_rd_addr = rd_idx[AW-1:0];
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (i_ctrl.cond)
            C_NEVER:    cond = 1'b0;
            // Upward sweeps serve a request equal to the head first; so do downward ones.
            C_SCAN:     cond = (r_idx < i_count)
                               && ((i_dir == DIR_DOWN) ? (i_rd_track <= r_head)
                                                       : (i_rd_track < r_head));
            C_IDX_LT_N: cond = (r_idx < i_count);
            C_IDX_GT_0: cond = (r_idx != '0);
            C_SPLIT_Z:  cond = (r_split == '0);
            C_SPLIT_N:  cond = (r_split == i_count);
            C_LAST_UP:  cond = ({1'b0, r_idx} + 1'b1) == {1'b0, r_split};
            C_LAST_DN:  cond = {1'b0, r_idx} == ({1'b0, r_split} + 1'b1);
            default:    cond = 1'b0;
        endcase
    end

    assign o_status.cond      = cond;
    assign o_status.slot_free = slot_free;

    always_comb begin
        case (i_ctrl.src)
            SRC_HEAD:     trk = r_head;
            SRC_STORE:    trk = i_rd_track;
            SRC_STORE_M1: trk = i_rd_track;
            SRC_EDGE:     trk = i_max_track;
            default:      trk = '0;
        endcase
    end

    assign e18 = SEEK_W'(i_max_track);
    assign h18 = SEEK_W'(r_head);
    assign v18 = SEEK_W'(i_rd_track);

    always_comb begin
        case (i_ctrl.seek)
            SEEK_TO_EDGE: seek_val = e18 - h18;
            SEEK_HEAD:    seek_val = h18;
            SEEK_WRAP_UP: seek_val = (e18 - h18) + e18 + v18;
            SEEK_WRAP_DN: seek_val = h18 + e18 + (e18 - v18);
            default:      seek_val = '0;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (i_ctrl.idx_upd) begin
            case (i_ctrl.idx_op)
                IDX_INC:   n_idx = r_idx + 1'b1;
                IDX_DEC:   n_idx = r_idx - 1'b1;
                IDX_ZERO:  n_idx = '0;
                IDX_COUNT: n_idx = i_count;
                default:   n_idx = r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_ctrl.split_ld) begin
            r_split <= r_idx;
        end
        if (i_start) begin
            r_head <= clamp_track(i_head, i_max_track);
        end
        if (i_ctrl.emit) begin
            r_out.service_track    <= trk;
            r_out.is_last          <= i_ctrl.last;
            r_out.total_seek       <= i_ctrl.last ? seek_val : '0;
            r_out.requests_dropped <= i_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
